// ----- rtl/ssdp_pkg.sv -----
// Shared types, constants and lookup functions for the sensor stream deframer and parser.
package ssdp_pkg;

   localparam int ByteW    = 8;
   localparam int WordW    = 16;
   localparam int PktCntW  = 5;
   localparam int CsrIdxW  = 2;
   localparam int NumWords = 5;
   localparam int WordIdxW = $clog2(NumWords);

   localparam logic [ByteW-1:0] HeaderReset   = 8'd19;
   localparam logic [WordW-1:0] CleanThReset  = 16'hFE70;
   localparam logic [WordW-1:0] DockThReset   = 16'hFFCE;

   localparam logic [ByteW-1:0] IdGroupAll    = 8'd0;
   localparam logic [ByteW-1:0] IdGroupShort  = 8'd1;
   localparam logic [ByteW-1:0] IdButtons     = 8'd7;
   localparam logic [ByteW-1:0] IdBumpers     = 8'd13;
   localparam logic [ByteW-1:0] IdDistance    = 8'd19;
   localparam logic [ByteW-1:0] IdChargeState = 8'd21;
   localparam logic [ByteW-1:0] IdVoltage     = 8'd22;
   localparam logic [ByteW-1:0] IdCurrent     = 8'd23;
   localparam logic [ByteW-1:0] IdCharge      = 8'd25;
   localparam logic [ByteW-1:0] IdCapacity    = 8'd26;
   localparam logic [ByteW-1:0] IdMode        = 8'd128;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN,
      PH_DATA,
      PH_CSUM
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_CKSUM  = 2'd1,
      ST_BAD_ID = 2'd2
   } status_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_HEADER,
      CSR_CLEAN_TH,
      CSR_DOCK_TH
   } csr_index_type;

   // Word slots come first so that they index the word array directly.
   typedef enum logic [2:0] {
      SLOT_DIST,
      SLOT_VOLT,
      SLOT_CUR,
      SLOT_CHARGE,
      SLOT_CAP,
      SLOT_CHG,
      SLOT_NONE
   } slot_type;

   typedef struct packed {
      logic [ByteW-1:0]        header;
      logic signed [WordW-1:0] clean_th;
      logic signed [WordW-1:0] dock_th;
   } cfg_type;

   typedef struct packed {
      status_type              status;
      logic signed [WordW-1:0] distance;
      logic [ByteW-1:0]        charging_state;
      logic [WordW-1:0]        voltage;
      logic signed [WordW-1:0] battery_current;
      logic [WordW-1:0]        charge;
      logic [WordW-1:0]        capacity;
      logic                    cleaning;
      logic                    docked;
   } result_type;

   typedef struct packed {
      logic               known;
      logic [PktCntW-1:0] data_bytes;
   } pkt_info_type;

   function automatic pkt_info_type packet_info(logic [ByteW-1:0] id);
      pkt_info_type info;
      info.known      = 1'b1;
      info.data_bytes = '0;
      case (id)
         IdGroupAll:    info.data_bytes = 5'd26;
         IdGroupShort:  info.data_bytes = 5'd10;
         IdButtons:     info.data_bytes = 5'd1;
         IdBumpers:     info.data_bytes = 5'd1;
         IdChargeState: info.data_bytes = 5'd1;
         IdMode:        info.data_bytes = 5'd1;
         IdDistance:    info.data_bytes = 5'd2;
         IdVoltage:     info.data_bytes = 5'd2;
         IdCurrent:     info.data_bytes = 5'd2;
         IdCharge:      info.data_bytes = 5'd2;
         IdCapacity:    info.data_bytes = 5'd2;
         default:       info.known      = 1'b0;
      endcase
      return info;
   endfunction

   function automatic slot_type slot_of(logic [ByteW-1:0] id);
      slot_type slot;
      case (id)
         IdDistance:    slot = SLOT_DIST;
         IdChargeState: slot = SLOT_CHG;
         IdVoltage:     slot = SLOT_VOLT;
         IdCurrent:     slot = SLOT_CUR;
         IdCharge:      slot = SLOT_CHARGE;
         IdCapacity:    slot = SLOT_CAP;
         default:       slot = SLOT_NONE;
      endcase
      return slot;
   endfunction

endpackage

// ----- rtl/ssdp_if.sv -----
// Channel interfaces: received bytes, parsed results and register writes.
interface ssdp_req_if;
   logic                        valid;
   logic                        ready;
   logic [ssdp_pkg::ByteW-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssdp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic signed [ssdp_pkg::WordW-1:0]  distance;
   logic [ssdp_pkg::ByteW-1:0]         charging_state;
   logic [ssdp_pkg::WordW-1:0]         voltage;
   logic signed [ssdp_pkg::WordW-1:0]  battery_current;
   logic [ssdp_pkg::WordW-1:0]         charge;
   logic [ssdp_pkg::WordW-1:0]         capacity;
   logic                               cleaning;
   logic                               docked;

   modport source (output valid, output status, output distance, output charging_state,
                   output voltage, output battery_current, output charge, output capacity,
                   output cleaning, output docked, input ready);
   modport sink (input valid, input status, input distance, input charging_state,
                 input voltage, input battery_current, input charge, input capacity,
                 input cleaning, input docked, output ready);
endinterface

interface ssdp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ssdp_pkg::CsrIdxW-1:0]  index;
   logic [ssdp_pkg::WordW-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sensor_stream_deframe_parse_top.sv -----
// Top level of the sensor stream deframer and packet parser.
// Throughput: one received byte per cycle; only a checksum byte can stall, and only
// while the result register still holds an untaken transaction.
// Latency: the result of a frame is valid on the response channel in the cycle after
// its checksum byte is accepted.
// Reset (synchronous): frame hunting restarts, the result register empties and the
// configuration registers return to header 19 and thresholds -400 and -50.
module sensor_stream_deframe_parse_top (
   input  logic         clock,
   input  logic         reset,
   ssdp_req_if.sink     req_chan,
   ssdp_rsp_if.source   rsp_chan,
   ssdp_csr_if.sink     csr_chan
);

   ssdp_pkg::cfg_type     cfg;
   ssdp_pkg::result_type  result;
   logic                  at_checksum;
   logic                  can_load;
   logic                  byte_accept;

   assign req_chan.ready = !at_checksum || can_load;
   assign byte_accept    = req_chan.valid && req_chan.ready;

   ssdp_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ssdp_frame_parser u_frame_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_chan.rx_byte),
      .cfg         (cfg),
      .at_checksum (at_checksum),
      .result      (result)
   );

   ssdp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (byte_accept && at_checksum),
      .result   (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- rtl/ssdp_csr_regs.sv -----
// Configuration registers: header byte and the two current thresholds.
module ssdp_csr_regs (
   input  logic                clock,
   input  logic                reset,
   ssdp_csr_if.sink            csr_chan,
   output ssdp_pkg::cfg_type   cfg
);

   ssdp_pkg::cfg_type cfg_ff, cfg_in;
   logic              write;

   assign csr_chan.ready = 1'b1;
   assign write          = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_chan.index)
            ssdp_pkg::CSR_HEADER:   cfg_in.header   = csr_chan.data[ssdp_pkg::ByteW-1:0];
            ssdp_pkg::CSR_CLEAN_TH: cfg_in.clean_th = csr_chan.data;
            ssdp_pkg::CSR_DOCK_TH:  cfg_in.dock_th  = csr_chan.data;
            default: begin
               // Writes to unlisted indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header   <= ssdp_pkg::HeaderReset;
         cfg_ff.clean_th <= ssdp_pkg::CleanThReset;
         cfg_ff.dock_th  <= ssdp_pkg::DockThReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ssdp_frame_parser.sv -----
// Frame tracking, running checksum, packet parsing and result formation.
module ssdp_frame_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_accept,
   input  logic [ssdp_pkg::ByteW-1:0]    rx_byte,
   input  ssdp_pkg::cfg_type             cfg,
   output logic                          at_checksum,
   output ssdp_pkg::result_type          result
);

   ssdp_pkg::phase_type           phase_ff, phase_in;
   logic [ssdp_pkg::ByteW-1:0]    payload_left_ff, payload_left_in;
   logic [ssdp_pkg::ByteW-1:0]    sum_ff, sum_in;
   ssdp_pkg::slot_type            slot_ff, slot_in;
   logic [ssdp_pkg::PktCntW-1:0]  pkt_left_ff, pkt_left_in;
   logic [ssdp_pkg::ByteW-1:0]    hold_ff, hold_in;
   logic                          bad_id_ff, bad_id_in;
   logic [ssdp_pkg::ByteW-1:0]    chg_ff, chg_in;
   logic [ssdp_pkg::WordW-1:0]    words_ff [ssdp_pkg::NumWords];
   logic [ssdp_pkg::WordW-1:0]    words_in [ssdp_pkg::NumWords];

   logic [ssdp_pkg::ByteW-1:0]    sum_add;
   ssdp_pkg::pkt_info_type        info;
   logic [ssdp_pkg::WordIdxW-1:0] word_idx;
   logic signed [ssdp_pkg::WordW-1:0] current;
   logic                          below_clean;

   assign sum_add     = sum_ff + rx_byte;
   assign info        = ssdp_pkg::packet_info(rx_byte);
   assign word_idx    = ssdp_pkg::WordIdxW'(slot_ff);
   assign at_checksum = (phase_ff == ssdp_pkg::PH_CSUM);

   // Next state of the frame sequencer.
   always_comb begin
      phase_in = phase_ff;
      if (byte_accept) begin
         case (phase_ff)
            ssdp_pkg::PH_IDLE: begin
               if (rx_byte == cfg.header) phase_in = ssdp_pkg::PH_LEN;
            end
            ssdp_pkg::PH_LEN: begin
               phase_in = (rx_byte == '0) ? ssdp_pkg::PH_CSUM : ssdp_pkg::PH_DATA;
            end
            ssdp_pkg::PH_DATA: begin
               if (payload_left_ff == ssdp_pkg::ByteW'(1)) phase_in = ssdp_pkg::PH_CSUM;
            end
            ssdp_pkg::PH_CSUM: phase_in = ssdp_pkg::PH_IDLE;
            default:           phase_in = ssdp_pkg::PH_IDLE;
         endcase
      end
   end

   // Checksum, length and packet parsing datapath.
   always_comb begin
      payload_left_in = payload_left_ff;
      sum_in          = sum_ff;
      slot_in         = slot_ff;
      pkt_left_in     = pkt_left_ff;
      hold_in         = hold_ff;
      bad_id_in       = bad_id_ff;
      chg_in          = chg_ff;
      for (int i = 0; i < ssdp_pkg::NumWords; i++) words_in[i] = words_ff[i];
      if (byte_accept) begin
         case (phase_ff)
            ssdp_pkg::PH_IDLE: sum_in = rx_byte;
            ssdp_pkg::PH_LEN: begin
               sum_in          = sum_add;
               payload_left_in = rx_byte;
               slot_in         = ssdp_pkg::SLOT_NONE;
               pkt_left_in     = '0;
               hold_in         = '0;
               bad_id_in       = 1'b0;
               chg_in          = '0;
               for (int i = 0; i < ssdp_pkg::NumWords; i++) words_in[i] = '0;
            end
            ssdp_pkg::PH_DATA: begin
               sum_in          = sum_add;
               payload_left_in = payload_left_ff - ssdp_pkg::ByteW'(1);
               if (!bad_id_ff) begin
                  if (pkt_left_ff == '0) begin
                     // Packet id byte.
                     slot_in = ssdp_pkg::slot_of(rx_byte);
                     if (info.known) pkt_left_in = info.data_bytes;
                     else bad_id_in = 1'b1;
                  end else begin
                     if (slot_ff == ssdp_pkg::SLOT_CHG) begin
                        chg_in = rx_byte;
                     end else if (slot_ff != ssdp_pkg::SLOT_NONE) begin
                        if (pkt_left_ff == ssdp_pkg::PktCntW'(2)) hold_in = rx_byte;
                        else words_in[word_idx] = {hold_ff, rx_byte};
                     end
                     pkt_left_in = pkt_left_ff - ssdp_pkg::PktCntW'(1);
                  end
               end
            end
            ssdp_pkg::PH_CSUM: sum_in = sum_add;
            default:           sum_in = sum_ff;
         endcase
      end
   end

   // Result for the checksum byte; it is only captured in that phase.
   assign current     = words_ff[ssdp_pkg::SLOT_CUR];
   assign below_clean = current < cfg.clean_th;

   always_comb begin
      result = '0;
      if (sum_add != '0) begin
         result.status = ssdp_pkg::ST_CKSUM;
      end else if (bad_id_ff) begin
         result.status = ssdp_pkg::ST_BAD_ID;
      end else begin
         result.status          = ssdp_pkg::ST_OK;
         result.distance        = words_ff[ssdp_pkg::SLOT_DIST];
         result.charging_state  = chg_ff;
         result.voltage         = words_ff[ssdp_pkg::SLOT_VOLT];
         result.battery_current = current;
         result.charge          = words_ff[ssdp_pkg::SLOT_CHARGE];
         result.capacity        = words_ff[ssdp_pkg::SLOT_CAP];
         result.cleaning        = below_clean;
         result.docked          = !below_clean && (current > cfg.dock_th);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ssdp_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Every field below is reloaded before it is used: the sum by the header byte, the rest by the length byte.
   always_ff @(posedge clock) begin
      payload_left_ff <= payload_left_in;
      sum_ff          <= sum_in;
      slot_ff         <= slot_in;
      pkt_left_ff     <= pkt_left_in;
      hold_ff         <= hold_in;
      bad_id_ff       <= bad_id_in;
      chg_ff          <= chg_in;
      for (int i = 0; i < ssdp_pkg::NumWords; i++) words_ff[i] <= words_in[i];
   end

endmodule

// ----- rtl/ssdp_out_reg.sv -----
// Result register that drives the response channel.
module ssdp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ssdp_pkg::result_type  result,
   output logic                  can_load,
   ssdp_rsp_if.source            rsp_chan
);

   logic                  valid_ff, valid_in;
   ssdp_pkg::result_type  data_ff;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_chan.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.status          = data_ff.status;
   assign rsp_chan.distance        = data_ff.distance;
   assign rsp_chan.charging_state  = data_ff.charging_state;
   assign rsp_chan.voltage         = data_ff.voltage;
   assign rsp_chan.battery_current = data_ff.battery_current;
   assign rsp_chan.charge          = data_ff.charge;
   assign rsp_chan.capacity        = data_ff.capacity;
   assign rsp_chan.cleaning        = data_ff.cleaning;
   assign rsp_chan.docked          = data_ff.docked;

endmodule

// ----- rtl/ssdp_checker.sv -----
// Port-level assertions for the sensor stream deframer, bound to the top level.
module ssdp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         status,
   input logic signed [ssdp_pkg::WordW-1:0]  distance,
   input logic [ssdp_pkg::ByteW-1:0]         charging_state,
   input logic [ssdp_pkg::WordW-1:0]         voltage,
   input logic signed [ssdp_pkg::WordW-1:0]  battery_current,
   input logic [ssdp_pkg::WordW-1:0]         charge,
   input logic [ssdp_pkg::WordW-1:0]         capacity,
   input logic                               cleaning,
   input logic                               docked
);

   // A pending transaction is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A failed frame reports no values and no flags.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ssdp_pkg::ST_OK |->
         distance == '0 && charging_state == '0 && voltage == '0 &&
         battery_current == '0 && charge == '0 && capacity == '0 && !cleaning && !docked)
      else $error("failed frame carries values");

   // Docked is only reported when not cleaning.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(cleaning && docked))
      else $error("cleaning and docked both set");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sensor_stream_deframe_parse_top ssdp_checker u_ssdp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .status          (rsp_chan.status),
   .distance        (rsp_chan.distance),
   .charging_state  (rsp_chan.charging_state),
   .voltage         (rsp_chan.voltage),
   .battery_current (rsp_chan.battery_current),
   .charge          (rsp_chan.charge),
   .capacity        (rsp_chan.capacity),
   .cleaning        (rsp_chan.cleaning),
   .docked          (rsp_chan.docked)
);

// ----- test/sensor_stream_deframe_parse_top_tb.sv -----
// Self-checking testbench for the sensor stream deframer with a cycle-free frame predictor.
module sensor_stream_deframe_parse_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Index 3 lies beyond the register list; writes to it must be dropped.
   localparam logic [ssdp_pkg::CsrIdxW-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [ssdp_pkg::ByteW-1:0] rx;
      bit                         typed;
      ssdp_pkg::status_type       st;
      logic [ssdp_pkg::WordW-1:0] cur;
      bit                         cl;
      bit                         dk;
   } directed_row_type;

   logic clock;
   logic reset;

   ssdp_req_if req_if();
   ssdp_rsp_if rsp_if();
   ssdp_csr_if csr_if();

   sensor_stream_deframe_parse_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Predictor state: configuration copy plus frame and packet tracking.
   ssdp_pkg::cfg_type          model_cfg;
   ssdp_pkg::phase_type        fr_phase;
   logic [ssdp_pkg::ByteW-1:0] fr_left;
   logic [ssdp_pkg::ByteW-1:0] fr_sum;
   logic [ssdp_pkg::ByteW-1:0] pk_id;
   logic [ssdp_pkg::ByteW-1:0] pk_hold;
   logic [4:0]                 pk_left;
   bit                         pk_bad;
   ssdp_pkg::result_type       fr_vals;

   ssdp_pkg::result_type expected_frames[$];
   int                   fail_count;
   int                   send_idle_pct;
   int                   rsp_idle_pct;
   int                   stream_bytes;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(99) >= rsp_idle_pct);
   end

   // Data bytes that follow a packet id, or -1 for an id the parser does not know.
   function automatic int pkt_data_bytes(logic [ssdp_pkg::ByteW-1:0] id);
      case (id)
         ssdp_pkg::IdGroupAll:         return 26;
         ssdp_pkg::IdGroupShort:       return 10;
         ssdp_pkg::IdButtons, ssdp_pkg::IdBumpers,
         ssdp_pkg::IdChargeState, ssdp_pkg::IdMode:
                                       return 1;
         ssdp_pkg::IdDistance, ssdp_pkg::IdVoltage, ssdp_pkg::IdCurrent,
         ssdp_pkg::IdCharge, ssdp_pkg::IdCapacity:
                                       return 2;
         default:                      return -1;
      endcase
   endfunction

   function automatic bit predict_frame(input logic [ssdp_pkg::ByteW-1:0] b,
                                        output ssdp_pkg::result_type res);
      int                         n;
      logic [ssdp_pkg::WordW-1:0] w;
      logic                       cl;
      res = '0;
      case (fr_phase)
         ssdp_pkg::PH_IDLE: begin
            if (b == model_cfg.header) begin
               fr_sum   = b;
               fr_phase = ssdp_pkg::PH_LEN;
            end
         end
         ssdp_pkg::PH_LEN: begin
            fr_sum   = fr_sum + b;
            fr_left  = b;
            pk_id    = '0;
            pk_left  = '0;
            pk_hold  = '0;
            pk_bad   = 1'b0;
            fr_vals  = '0;
            fr_phase = (b == 8'd0) ? ssdp_pkg::PH_CSUM : ssdp_pkg::PH_DATA;
         end
         ssdp_pkg::PH_DATA: begin
            fr_sum = fr_sum + b;
            if (!pk_bad) begin
               if (pk_left == 5'd0) begin
                  pk_id = b;
                  n = pkt_data_bytes(b);
                  if (n < 0) pk_bad = 1'b1;
                  else pk_left = 5'(n);
               end else begin
                  case (pk_id)
                     ssdp_pkg::IdChargeState: fr_vals.charging_state = b;
                     ssdp_pkg::IdDistance, ssdp_pkg::IdVoltage, ssdp_pkg::IdCurrent,
                     ssdp_pkg::IdCharge, ssdp_pkg::IdCapacity: begin
                        if (pk_left == 5'd2) begin
                           pk_hold = b;
                        end else begin
                           w = {pk_hold, b};
                           case (pk_id)
                              ssdp_pkg::IdDistance: fr_vals.distance        = w;
                              ssdp_pkg::IdVoltage:  fr_vals.voltage         = w;
                              ssdp_pkg::IdCurrent:  fr_vals.battery_current = w;
                              ssdp_pkg::IdCharge:   fr_vals.charge          = w;
                              default:              fr_vals.capacity        = w;
                           endcase
                        end
                     end
                     default: ;
                  endcase
                  pk_left = pk_left - 5'd1;
               end
            end
            fr_left = fr_left - 8'd1;
            if (fr_left == 8'd0) fr_phase = ssdp_pkg::PH_CSUM;
         end
         default: begin
            fr_sum   = fr_sum + b;
            fr_phase = ssdp_pkg::PH_IDLE;
            if (fr_sum != 8'd0) begin
               res.status = ssdp_pkg::ST_CKSUM;
            end else if (pk_bad) begin
               res.status = ssdp_pkg::ST_BAD_ID;
            end else begin
               res        = fr_vals;
               res.status = ssdp_pkg::ST_OK;
               cl = $signed(fr_vals.battery_current) < $signed(model_cfg.clean_th);
               res.cleaning = cl;
               res.docked = !cl &&
                  ($signed(fr_vals.battery_current) > $signed(model_cfg.dock_th));
            end
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(string name, logic [ssdp_pkg::WordW-1:0] want,
                                       logic [ssdp_pkg::WordW-1:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      ssdp_pkg::result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_frames.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected frame result, status %0d", $time, rsp_if.status);
         end else begin
            want = expected_frames.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_if.status));
            check_field("distance", want.distance, rsp_if.distance);
            check_field("charging_state", 16'(want.charging_state),
                        16'(rsp_if.charging_state));
            check_field("voltage", want.voltage, rsp_if.voltage);
            check_field("battery_current", want.battery_current, rsp_if.battery_current);
            check_field("charge", want.charge, rsp_if.charge);
            check_field("capacity", want.capacity, rsp_if.capacity);
            check_field("cleaning", 16'(want.cleaning), 16'(rsp_if.cleaning));
            check_field("docked", 16'(want.docked), 16'(rsp_if.docked));
         end
      end
   end

   task automatic push_byte(input logic [ssdp_pkg::ByteW-1:0] b);
      ssdp_pkg::result_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid   = 1'b0;
         req_if.rx_byte = 8'($urandom_range(255));
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.rx_byte = b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (predict_frame(b, res)) expected_frames.push_back(res);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ssdp_pkg::CsrIdxW-1:0] idx,
                            input logic [ssdp_pkg::WordW-1:0] data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         ssdp_pkg::CSR_HEADER:   model_cfg.header   = data[ssdp_pkg::ByteW-1:0];
         ssdp_pkg::CSR_CLEAN_TH: model_cfg.clean_th = data;
         ssdp_pkg::CSR_DOCK_TH:  model_cfg.dock_th  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic logic [ssdp_pkg::ByteW-1:0] payload_byte();
      // Header values inside a frame must be treated as plain data.
      return ($urandom_range(9) == 0) ? model_cfg.header : 8'($urandom_range(255));
   endfunction

   function automatic logic [ssdp_pkg::WordW-1:0] current_near_threshold();
      logic [ssdp_pkg::WordW-1:0] base;
      base = $urandom_range(1) ? model_cfg.clean_th : model_cfg.dock_th;
      return base + 16'($urandom_range(2)) - 16'd1;
   endfunction

   task automatic send_random_frame();
      logic [ssdp_pkg::ByteW-1:0] body[$];
      logic [ssdp_pkg::ByteW-1:0] id;
      logic [ssdp_pkg::ByteW-1:0] sum;
      logic [ssdp_pkg::ByteW-1:0] csum;
      logic [ssdp_pkg::WordW-1:0] w;
      int                         target;
      int                         n;
      int                         p;
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      p = $urandom_range(99);
      if (p < 5) target = $urandom_range(100, 255);
      else if (p < 12) target = $urandom_range(28, 60);
      else target = $urandom_range(0, 16);
      while (body.size() < target) begin
         p = $urandom_range(99);
         if (p < 4) begin
            id = 8'($urandom_range(255));
         end else if (p < 10) begin
            id = ssdp_pkg::IdGroupAll;
         end else if (p < 16) begin
            id = ssdp_pkg::IdGroupShort;
         end else if (p < 28) begin
            case ($urandom_range(2))
               0:       id = ssdp_pkg::IdButtons;
               1:       id = ssdp_pkg::IdBumpers;
               default: id = ssdp_pkg::IdMode;
            endcase
         end else if (p < 40) begin
            id = ssdp_pkg::IdChargeState;
         end else begin
            case ($urandom_range(4))
               0:       id = ssdp_pkg::IdDistance;
               1:       id = ssdp_pkg::IdVoltage;
               2:       id = ssdp_pkg::IdCurrent;
               3:       id = ssdp_pkg::IdCharge;
               default: id = ssdp_pkg::IdCapacity;
            endcase
         end
         body.push_back(id);
         n = pkt_data_bytes(id);
         if (id == ssdp_pkg::IdCurrent && $urandom_range(2) != 0) begin
            w = current_near_threshold();
            body.push_back(w[15:8]);
            body.push_back(w[7:0]);
         end else begin
            for (int k = 0; k < n; k++) body.push_back(payload_byte());
         end
      end
      // Trimming to the length byte leaves the last packet cut off now and then.
      while (body.size() > target) void'(body.pop_back());
      sum = model_cfg.header + 8'(target);
      foreach (body[k]) sum = sum + body[k];
      csum = 8'd0 - sum;
      if ($urandom_range(99) < 12) csum = csum + 8'($urandom_range(1, 255));
      push_byte(model_cfg.header);
      push_byte(8'(target));
      foreach (body[k]) push_byte(body[k]);
      push_byte(csum);
      stream_bytes += target + 3;
   endtask

   task automatic run_traffic(input int send_pct, input int rsp_pct, input int budget);
      int frames;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      stream_bytes  = 0;
      frames        = 0;
      while (stream_bytes < budget) begin
         send_random_frame();
         frames++;
         // Hold the stream off now and then until every frame result is back.
         if (frames % 40 == 0) drain_results();
      end
      drain_results();
   endtask

   task automatic run_directed();
      directed_row_type     rows[28];
      ssdp_pkg::result_type typed;
      rows = '{
         '{8'hFF,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         // Empty payload: the byte after the length is the checksum.
         '{ssdp_pkg::HeaderReset, 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'h00,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd237,                1'b1, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b1},
         '{ssdp_pkg::HeaderReset, 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'h00,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'h00,                 1'b1, ssdp_pkg::ST_CKSUM,  16'h0000, 1'b0, 1'b0},
         '{ssdp_pkg::HeaderReset, 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd1,                  1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'hFF,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd237,                1'b1, ssdp_pkg::ST_BAD_ID, 16'h0000, 1'b0, 1'b0},
         '{ssdp_pkg::HeaderReset, 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd3,                  1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{ssdp_pkg::IdCurrent,   1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'h80,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'h00,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd83,                 1'b1, ssdp_pkg::ST_OK,     16'h8000, 1'b1, 1'b0},
         '{ssdp_pkg::HeaderReset, 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd3,                  1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{ssdp_pkg::IdCurrent,   1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'h7F,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'hFF,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd85,                 1'b1, ssdp_pkg::ST_OK,     16'h7FFF, 1'b0, 1'b1},
         // The voltage packet is cut off by the length, so voltage stays zero.
         '{ssdp_pkg::HeaderReset, 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd2,                  1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{ssdp_pkg::IdVoltage,   1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'hFF,                 1'b0, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b0},
         '{8'd214,                1'b1, ssdp_pkg::ST_OK,     16'h0000, 1'b0, 1'b1}
      };
      foreach (rows[k]) begin
         push_byte(rows[k].rx);
         if (rows[k].typed) begin
            typed                 = '0;
            typed.status          = rows[k].st;
            typed.battery_current = rows[k].cur;
            typed.cleaning        = rows[k].cl;
            typed.docked          = rows[k].dk;
            expected_frames[$]    = typed;
         end
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      model_cfg      = '{ssdp_pkg::HeaderReset, ssdp_pkg::CleanThReset,
                         ssdp_pkg::DockThReset};
      fr_phase       = ssdp_pkg::PH_IDLE;
      fr_left        = '0;
      fr_sum         = '0;
      pk_id          = '0;
      pk_hold        = '0;
      pk_left        = '0;
      pk_bad         = 1'b0;
      fr_vals        = '0;
      fail_count     = 0;
      send_idle_pct  = 8;
      rsp_idle_pct   = 65;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      drain_results();

      // Thresholds at the extremes: neither cleaning nor docked can be reported.
      write_csr(ssdp_pkg::CSR_HEADER, 16'h0000);
      write_csr(ssdp_pkg::CSR_CLEAN_TH, 16'h8000);
      write_csr(ssdp_pkg::CSR_DOCK_TH, 16'h7FFF);
      write_csr(CSR_UNMAPPED, 16'($urandom_range(65535)));
      run_traffic(8, 65, 500);

      write_csr(ssdp_pkg::CSR_HEADER, 16'h00FF);
      write_csr(ssdp_pkg::CSR_CLEAN_TH, 16'h7FFF);
      write_csr(ssdp_pkg::CSR_DOCK_TH, 16'h8000);
      run_traffic(65, 8, 500);

      write_csr(ssdp_pkg::CSR_HEADER, 16'($urandom_range(255)));
      write_csr(ssdp_pkg::CSR_CLEAN_TH, 16'($urandom_range(65535)));
      write_csr(ssdp_pkg::CSR_DOCK_TH, 16'($urandom_range(65535)));
      run_traffic(0, 0, 500);

      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_frames.size() == 0) begin
         $display("sensor_stream_deframe_parse_top_tb: PASS");
      end else begin
         $display("sensor_stream_deframe_parse_top_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("sensor_stream_deframe_parse_top_tb: FAIL");
      $finish;
   end

endmodule
